// ===== rtl/core/nrd_pkg.sv =====
// Shared widths and item types for the non-restoring divider.
package nrd_pkg;

    // Operand width of the divider.
    localparam int DIV_W = 8;

    // The partial remainder is signed and needs two bits over the operand width.
    localparam int REM_W = DIV_W + 2;

    typedef struct packed {
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } nrd_in_t;

    typedef struct packed {
        logic [DIV_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } nrd_out_t;

    // Data handed from one cell of the chain to the next.
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DIV_W-1:0] quo;
        logic [DIV_W-1:0] dsr;
    } nrd_stage_t;

endpackage

// ===== rtl/core/nrd_cell.sv =====
// One non-restoring division step with its own stage register.
module nrd_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  nrd_pkg::nrd_stage_t in_stage,
    output logic                out_valid,
    input  logic                out_ready,
    output nrd_pkg::nrd_stage_t out_stage
);

    logic                       valid_reg;
    nrd_pkg::nrd_stage_t        stage_reg;
    nrd_pkg::nrd_stage_t        stage_next;
    logic [nrd_pkg::REM_W-1:0]  shifted;
    logic [nrd_pkg::REM_W-1:0]  dsr_ext;
    logic [nrd_pkg::REM_W-1:0]  rem_new;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        // Shift the top quotient-register bit into the partial remainder.
        shifted = {in_stage.rem[nrd_pkg::REM_W-2:0], in_stage.quo[nrd_pkg::DIV_W-1]};
        dsr_ext = {2'b00, in_stage.dsr};
        if (shifted[nrd_pkg::REM_W-1]) begin
            rem_new = shifted + dsr_ext;
        end else begin
            rem_new = shifted - dsr_ext;
        end
        stage_next.rem = rem_new;
        stage_next.quo = {in_stage.quo[nrd_pkg::DIV_W-2:0], ~rem_new[nrd_pkg::REM_W-1]};
        stage_next.dsr = in_stage.dsr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

// ===== rtl/core/nrd_fix.sv =====
// Final remainder correction and output register of the divider.
module nrd_fix (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  nrd_pkg::nrd_stage_t in_stage,
    output logic                out_valid,
    input  logic                out_ready,
    output nrd_pkg::nrd_out_t   out_data
);

    logic                       valid_reg;
    nrd_pkg::nrd_out_t          data_reg;
    nrd_pkg::nrd_out_t          data_next;
    logic [nrd_pkg::REM_W-1:0]  rem_fixed;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        // A negative remainder gets the divisor added back once.
        if (in_stage.rem[nrd_pkg::REM_W-1]) begin
            rem_fixed = in_stage.rem + {2'b00, in_stage.dsr};
        end else begin
            rem_fixed = in_stage.rem;
        end
        data_next.quotient  = in_stage.quo;
        data_next.remainder = rem_fixed[nrd_pkg::DIV_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/core/nonrestoring_divider_top.sv =====
// Top level of the pipelined non-restoring unsigned divider.
// Each division step is a cell of its own, followed by the correction stage.
// Throughput: one item per cycle while the result side takes items (m_ready high).
// An empty stage takes a new item even when the stage after it is stalled.
// Reset: aresetn is synchronous and active low; it clears every stage's valid bit.
// Data registers are not reset.
module nonrestoring_divider_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  nrd_pkg::nrd_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output nrd_pkg::nrd_out_t m_data
);

    // Handshake and data between neighbors in the chain. Index 0 is the
    // input side; index DIV_W is what the last step cell hands to the
    // correction stage.
    logic                valid_w [nrd_pkg::DIV_W+1];
    logic                ready_w [nrd_pkg::DIV_W+1];
    nrd_pkg::nrd_stage_t stage_w [nrd_pkg::DIV_W+1];

    // The first cell starts with a zero partial remainder and the dividend in
    // the quotient register, as the textbook shift-register form does.
    assign valid_w[0]     = s_valid;
    assign s_ready        = ready_w[0];
    assign stage_w[0].rem = '0;
    assign stage_w[0].quo = s_data.dividend;
    assign stage_w[0].dsr = s_data.divisor;

    // One cell per quotient bit. Each cell holds one item and passes it on as
    // soon as its neighbor has room, so stalls only back up through full cells.
    for (genvar i = 0; i < nrd_pkg::DIV_W; i++) begin : g_step
        nrd_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (valid_w[i]),
            .in_ready  (ready_w[i]),
            .in_stage  (stage_w[i]),
            .out_valid (valid_w[i+1]),
            .out_ready (ready_w[i+1]),
            .out_stage (stage_w[i+1])
        );
    end

    // The last stage corrects a negative remainder and drives the result port
    // from its own register.
    nrd_fix u_fix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (valid_w[nrd_pkg::DIV_W]),
        .in_ready  (ready_w[nrd_pkg::DIV_W]),
        .in_stage  (stage_w[nrd_pkg::DIV_W]),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

// ===== rtl/core/nrd_checker.sv =====
// Port-level checks of the divider, bound to the top level.
module nrd_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input nrd_pkg::nrd_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input nrd_pkg::nrd_out_t m_data
);

    // Nothing comes out right after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // A waiting input item holds until it is taken.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("waiting input item changed");

    // With the output stage empty, no stage can be blocking the input.
    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked while output empty");

    // While the result side takes items, every stage has room, so the input
    // stays open.
    a_flow_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input blocked while output drains");

endmodule

bind nonrestoring_divider_top nrd_checker u_nrd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== verif/testbench.sv =====
// Self-checking testbench for the pipelined non-restoring unsigned divider.
`timescale 1ns / 100ps

module testbench;

    localparam int CLK_PERIOD     = 12;
    localparam int RANDOM_ITEMS   = 1350;
    // Far beyond the slowest legal run: every item waiting out the longest
    // sender gap, the longest receiver stall and the full pipeline latency.
    localparam int TIMEOUT_CYCLES = 800_000;
    localparam int DRAIN_LIMIT    = 20_000;
    localparam int TAIL_CYCLES    = nrd_pkg::DIV_W + 6;
    localparam int MAX_ERROR_LINES = 50;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    nrd_pkg::nrd_in_t  s_data;
    logic              m_valid;
    logic              m_ready;
    nrd_pkg::nrd_out_t m_data;

    // Operand pairs still to be sent, and the quotient/remainder pairs that
    // the divider owes us, oldest first.
    nrd_pkg::nrd_in_t  operand_queue[$];
    nrd_pkg::nrd_out_t quot_rem_expected[$];

    int error_count    = 0;
    int sent_count     = 0;
    int zero_div_count = 0;
    int checked_count  = 0;

    // Set at each rising edge when the input item on the bus was taken.
    bit in_took = 1'b0;

    int in_gap_left   = 0;
    int in_calm_left  = 0;
    int out_stall_left = 0;
    int out_calm_left  = 0;

    nonrestoring_divider_top i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Bit-true model of the divider: DIV_W shift-and-add/subtract steps on a
    // signed partial remainder, followed by one correction of a negative
    // remainder. A zero divisor falls out as an all-ones quotient with the
    // dividend left as the remainder.
    function automatic nrd_pkg::nrd_out_t divide_nonrestoring(nrd_pkg::nrd_in_t op);
        logic [nrd_pkg::DIV_W-1:0] quo;
        int                        part_rem;
        int                        dsr;
        nrd_pkg::nrd_out_t         res;
        quo      = op.dividend;
        dsr      = int'(op.divisor);
        part_rem = 0;
        for (int i = 0; i < nrd_pkg::DIV_W; i++) begin
            part_rem = part_rem * 2 + int'(quo[nrd_pkg::DIV_W-1]);
            quo      = quo << 1;
            if (part_rem >= 0) begin
                part_rem = part_rem - dsr;
            end else begin
                part_rem = part_rem + dsr;
            end
            if (part_rem >= 0) begin
                quo[0] = 1'b1;
            end
        end
        if (part_rem < 0) begin
            part_rem = part_rem + dsr;
        end
        res.quotient  = quo;
        res.remainder = part_rem[nrd_pkg::DIV_W-1:0];
        return res;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic add_pair(input int dvd, input int dsr);
        nrd_pkg::nrd_in_t op;
        op.dividend = dvd[nrd_pkg::DIV_W-1:0];
        op.divisor  = dsr[nrd_pkg::DIV_W-1:0];
        operand_queue.push_back(op);
    endtask

    task automatic report_error(input string msg);
        if (error_count < MAX_ERROR_LINES) begin
            $display("[%0t] ERROR: %s", $time, msg);
        end
        error_count++;
    endtask

    // Input driver: changes s_valid and s_data on the falling edge only. An
    // item that is up stays up, unchanged, until a rising edge takes it.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_took) begin
            if (in_gap_left > 0) begin
                in_gap_left--;
                s_valid <= 1'b0;
                // Idle cycles carry junk so the divider must honor s_valid.
                s_data  <= nrd_pkg::nrd_in_t'($urandom);
            end else if (operand_queue.size() != 0) begin
                s_data  <= operand_queue.pop_front();
                s_valid <= 1'b1;
                if (in_calm_left > 0) begin
                    in_calm_left--;
                    in_gap_left = 0;
                end else begin
                    in_gap_left = random_gap();
                    if ($urandom_range(0, 49) == 0) begin
                        in_calm_left = $urandom_range(20, 80);
                    end
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result-side back-pressure, also changed on the falling edge only.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (out_stall_left > 0) begin
            out_stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (out_calm_left > 0) begin
                out_calm_left--;
            end else begin
                out_stall_left = random_gap();
                if ($urandom_range(0, 49) == 0) begin
                    out_calm_left = $urandom_range(20, 80);
                end
            end
        end
    end

    // Monitor: both handshakes are sampled at the rising edge. Accepted
    // operands go through the model; each result is held against the oldest
    // expectation.
    always @(posedge aclk) begin
        nrd_pkg::nrd_out_t want;
        in_took = aresetn && s_valid && s_ready;
        if (in_took) begin
            quot_rem_expected.push_back(divide_nonrestoring(s_data));
            sent_count++;
            if (s_data.divisor == '0) begin
                zero_div_count++;
            end
        end
        if (aresetn && m_valid && m_ready) begin
            if (quot_rem_expected.size() == 0) begin
                report_error($sformatf("unexpected result q=%0d r=%0d",
                                       m_data.quotient, m_data.remainder));
            end else begin
                want = quot_rem_expected.pop_front();
                checked_count++;
                if (m_data.quotient !== want.quotient) begin
                    report_error($sformatf("result %0d: quotient %0d, expected %0d",
                                           checked_count, m_data.quotient,
                                           want.quotient));
                end
                if (m_data.remainder !== want.remainder) begin
                    report_error($sformatf("result %0d: remainder %0d, expected %0d",
                                           checked_count, m_data.remainder,
                                           want.remainder));
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int kind;
        int dsr;
        int drain;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        m_ready = 1'b0;

        // Directed corners: operand extremes, division by zero, divisor
        // larger than dividend, exact multiples and alternating bit patterns.
        add_pair(0,   0);
        add_pair(255, 0);
        add_pair(1,   0);
        add_pair(170, 0);
        add_pair(0,   255);
        add_pair(255, 255);
        add_pair(255, 1);
        add_pair(0,   1);
        add_pair(1,   1);
        add_pair(1,   255);
        add_pair(254, 255);
        add_pair(255, 254);
        add_pair(128, 2);
        add_pair(127, 128);
        add_pair(128, 127);
        add_pair(170, 85);
        add_pair(85,  170);
        add_pair(200, 7);
        add_pair(255, 15);
        add_pair(240, 15);
        add_pair(100, 3);
        add_pair(255, 128);

        // Random pairs: mostly uniform, with extra weight on small divisors,
        // zero divisors, divisors at or above the dividend and exact divisions.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            kind = $urandom_range(0, 99);
            if (kind < 50) begin
                add_pair($urandom_range(0, 255), $urandom_range(0, 255));
            end else if (kind < 65) begin
                add_pair($urandom_range(0, 255), $urandom_range(1, 15));
            end else if (kind < 72) begin
                add_pair($urandom_range(0, 255), 0);
            end else if (kind < 87) begin
                dsr = $urandom_range(1, 255);
                add_pair($urandom_range(0, dsr), dsr);
            end else begin
                dsr = $urandom_range(1, 255);
                add_pair(dsr * $urandom_range(0, 255 / dsr), dsr);
            end
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Every operand pair must be taken, then every result must come out.
        while (operand_queue.size() != 0 || s_valid) begin
            @(posedge aclk);
        end
        drain = 0;
        while (quot_rem_expected.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain++;
        end
        // A few more cycles so a stray extra result would still be caught.
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (quot_rem_expected.size() != 0) begin
            report_error($sformatf("%0d results never arrived",
                                   quot_rem_expected.size()));
        end

        $display("Divided %0d operand pairs (%0d by zero) and checked %0d results;",
                 sent_count, zero_div_count, checked_count);
        $display("%0d mismatches found.", error_count);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Timeout after %0d cycles", TIMEOUT_CYCLES);
        $display("Verification failed");
        $finish;
    end

endmodule
